>>> rtl/core/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared command codes and field widths of the code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int CodeWidth  = 32;
  localparam int LenWidth   = 6;
  localparam int TotalWidth = 48;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_LOAD   = 2'd0;
  localparam cmd_t CMD_ENCODE = 2'd1;
  localparam cmd_t CMD_FLUSH  = 2'd2;

endpackage

>>> rtl/core/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Variable-length code encoder that packs code bits LSB first into bytes.
// ----------------------------------------------------------------------------
// An input word is taken in every cycle while the lookup stage can move on.
// The symbol's code and length are read from a code RAM with a registered
// read port, then merged with the pending byte in a single step. A load or
// an encode that fills no byte leaves without waiting on the output; an
// encode that fills k bytes (at most four at the default code length) or a
// flush that emits one byte waits for the burst register, so the sustained
// rate is set by the single byte output and its burst register. Code lengths
// have one loaded flag per symbol that reset clears at once.
module huffman_code_bit_packer_unit
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            cmd,
  input  logic [7:0]            symbol,
  input  logic [CodeWidth-1:0]  code_value,
  input  logic [LenWidth-1:0]   code_length,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  last,
  output logic [TotalWidth-1:0] total_bits
);

  localparam int AW = $clog2(SYMBOL_COUNT > 1 ? SYMBOL_COUNT : 2);
  localparam int CapInt = MAX_CODE_LEN < CodeWidth ? MAX_CODE_LEN : CodeWidth;
  localparam logic [LenWidth-1:0] LenCap = LenWidth'(CapInt);
  localparam int EntryWidth = CodeWidth + LenWidth;

  logic                  in_fire;
  logic                  in_range;
  logic [AW-1:0]         addr;
  logic [LenWidth-1:0]   len_sat;
  logic                  ram_we;
  logic [EntryWidth-1:0] ram_rdata;

  logic [SYMBOL_COUNT-1:0] loaded;

  logic                  s1_valid;
  logic                  s1_encode;
  logic                  s1_flush;
  logic                  s1_loaded;

  logic [7:0]            pending_byte;
  logic [2:0]            bit_position;
  logic [TotalWidth-1:0] bit_total;

  logic [31:0]           burst;
  logic [2:0]            burst_count;
  logic [TotalWidth-1:0] burst_total;

  logic [LenWidth-1:0]   len_eff;
  logic [CodeWidth-1:0]  code_masked;
  logic [39:0]           acc;
  logic [5:0]            bit_sum;
  logic [2:0]            n_bytes;
  logic [2:0]            s1_n;
  logic [31:0]           s1_data;
  logic                  burst_free;
  logic                  s1_fire;
  logic                  out_fire;

  assign in_fire  = in_valid && in_ready;
  assign in_range = {1'b0, symbol} < 9'(SYMBOL_COUNT);
  assign addr     = symbol[AW-1:0];
  assign len_sat  = (code_length > LenCap) ? LenCap : code_length;
  assign ram_we   = in_fire && (cmd_t'(cmd) == CMD_LOAD) && in_range;

  hcbp_ram #(
    .WIDTH(EntryWidth),
    .DEPTH(SYMBOL_COUNT)
  ) u_code_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata({len_sat, code_value}),
    .re   (in_fire),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  assign len_eff     = s1_loaded ? ram_rdata[EntryWidth-1:CodeWidth] : '0;
  assign code_masked = ram_rdata[CodeWidth-1:0] & ~({CodeWidth{1'b1}} << len_eff);
  assign acc         = {32'b0, pending_byte} | ({8'b0, code_masked} << bit_position);
  assign bit_sum     = {3'b0, bit_position} + len_eff;
  assign n_bytes     = bit_sum[5:3];

  always_comb begin
    s1_n    = 3'd0;
    s1_data = acc[31:0];
    if (s1_encode) begin
      s1_n = n_bytes;
    end else if (s1_flush) begin
      s1_n    = (bit_position != 3'd0) ? 3'd1 : 3'd0;
      s1_data = {24'b0, pending_byte};
    end
  end

  assign out_valid  = burst_count != 3'd0;
  assign out_fire   = out_valid && out_ready;
  assign burst_free = (burst_count == 3'd0) || ((burst_count == 3'd1) && out_ready);
  assign s1_fire    = s1_valid && ((s1_n == 3'd0) || burst_free);
  assign in_ready   = !s1_valid || s1_fire;

  assign out_byte   = burst[7:0];
  assign last       = burst_count == 3'd1;
  assign total_bits = burst_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (ram_we) begin
      loaded[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_encode <= 1'b0;
      s1_flush  <= 1'b0;
    end else if (in_fire) begin
      s1_valid  <= 1'b1;
      s1_encode <= (cmd_t'(cmd) == CMD_ENCODE) && in_range;
      s1_flush  <= cmd_t'(cmd) == CMD_FLUSH;
    end else if (s1_fire) begin
      s1_valid  <= 1'b0;
      s1_encode <= 1'b0;
      s1_flush  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_loaded <= loaded[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_byte <= '0;
      bit_position <= '0;
      bit_total    <= '0;
    end else if (s1_fire && s1_encode) begin
      pending_byte <= 8'(acc >> {n_bytes, 3'b000});
      bit_position <= bit_sum[2:0];
      bit_total    <= bit_total + TotalWidth'(len_eff);
    end else if (s1_fire && s1_flush) begin
      pending_byte <= '0;
      bit_position <= '0;
      bit_total    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_count <= '0;
    end else if (s1_fire && (s1_n != 3'd0)) begin
      burst_count <= s1_n;
    end else if (out_fire) begin
      burst_count <= burst_count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_n != 3'd0)) begin
      burst       <= s1_data;
      burst_total <= s1_encode ? bit_total + TotalWidth'(len_eff) : bit_total;
    end else if (out_fire) begin
      burst <= {8'b0, burst[31:8]};
    end
  end

endmodule
